// ----- sv/wrsi_pkg.sv -----
package wrsi_pkg;

  localparam int unsigned MAX_PERIOD   = 255;
  localparam logic [7:0]  RESET_PERIOD = 8'd14;
  localparam logic [7:0]  MIN_PERIOD   = 8'd2;

  localparam int unsigned PC_W         = 5;
  localparam logic [5:0]  DIV_P_STEPS  = 6'd48;
  localparam logic [5:0]  DIV_R_STEPS  = 6'd17;
  localparam logic [16:0] RSI_ONE      = 17'd65536;

  localparam logic [PC_W-1:0] A_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] A_DISPATCH = 5'd1;
  localparam logic [PC_W-1:0] A_SEED_ADD = 5'd3;
  localparam logic [PC_W-1:0] A_SDIV_G   = 5'd6;
  localparam logic [PC_W-1:0] A_SDIV_L   = 5'd9;
  localparam logic [PC_W-1:0] A_WILD     = 5'd11;
  localparam logic [PC_W-1:0] A_WDIV_G   = 5'd13;
  localparam logic [PC_W-1:0] A_WDIV_L   = 5'd17;
  localparam logic [PC_W-1:0] A_RSI      = 5'd19;
  localparam logic [PC_W-1:0] A_RDIV     = 5'd21;
  localparam logic [PC_W-1:0] A_EMIT_Q   = 5'd22;
  localparam logic [PC_W-1:0] A_ONE      = 5'd24;
  localparam logic [PC_W-1:0] A_ZERO     = 5'd26;
  localparam logic [PC_W-1:0] A_FIRST    = 5'd28;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FIRST,
    OP_SEED_ADD,
    OP_SEED_LOAD,
    OP_MUL,
    OP_WILD_LOAD,
    OP_DIV_STEP,
    OP_STORE,
    OP_RSI_LOAD,
    OP_EMIT_Q,
    OP_EMIT_ONE,
    OP_EMIT_ZERO
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_FIRST,
    C_SMOOTH,
    C_SEEDING,
    C_DIV_MORE,
    C_LOSS_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    logic            sel_loss;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t uw(input op_t o, input logic s, input cond_t c,
                                input logic [PC_W-1:0] t);
    ucode_t w;
    w.op       = o;
    w.sel_loss = s;
    w.cond     = c;
    w.target   = t;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] a);
    ucode_t w;
    w = uw(OP_NONE, 1'b0, C_ALWAYS, A_IDLE);
    unique case (a)
      5'd0:  w = uw(OP_ACCEPT,    1'b0, C_NO_IN,     A_IDLE);
      5'd1:  w = uw(OP_NONE,      1'b0, C_FIRST,     A_FIRST);
      5'd2:  w = uw(OP_NONE,      1'b0, C_SMOOTH,    A_WILD);
      5'd3:  w = uw(OP_SEED_ADD,  1'b0, C_NEVER,     A_IDLE);
      5'd4:  w = uw(OP_NONE,      1'b0, C_SEEDING,   A_ZERO);
      5'd5:  w = uw(OP_SEED_LOAD, 1'b0, C_NEVER,     A_IDLE);
      5'd6:  w = uw(OP_DIV_STEP,  1'b0, C_DIV_MORE,  A_SDIV_G);
      5'd7:  w = uw(OP_STORE,     1'b0, C_NEVER,     A_IDLE);
      5'd8:  w = uw(OP_SEED_LOAD, 1'b1, C_NEVER,     A_IDLE);
      5'd9:  w = uw(OP_DIV_STEP,  1'b1, C_DIV_MORE,  A_SDIV_L);
      5'd10: w = uw(OP_STORE,     1'b1, C_ALWAYS,    A_RSI);
      5'd11: w = uw(OP_MUL,       1'b0, C_NEVER,     A_IDLE);
      5'd12: w = uw(OP_WILD_LOAD, 1'b0, C_NEVER,     A_IDLE);
      5'd13: w = uw(OP_DIV_STEP,  1'b0, C_DIV_MORE,  A_WDIV_G);
      5'd14: w = uw(OP_STORE,     1'b0, C_NEVER,     A_IDLE);
      5'd15: w = uw(OP_MUL,       1'b1, C_NEVER,     A_IDLE);
      5'd16: w = uw(OP_WILD_LOAD, 1'b1, C_NEVER,     A_IDLE);
      5'd17: w = uw(OP_DIV_STEP,  1'b1, C_DIV_MORE,  A_WDIV_L);
      5'd18: w = uw(OP_STORE,     1'b1, C_NEVER,     A_IDLE);
      5'd19: w = uw(OP_NONE,      1'b0, C_LOSS_ZERO, A_ONE);
      5'd20: w = uw(OP_RSI_LOAD,  1'b0, C_NEVER,     A_IDLE);
      5'd21: w = uw(OP_DIV_STEP,  1'b0, C_DIV_MORE,  A_RDIV);
      5'd22: w = uw(OP_EMIT_Q,    1'b0, C_OUT_BUSY,  A_EMIT_Q);
      5'd23: w = uw(OP_NONE,      1'b0, C_ALWAYS,    A_IDLE);
      5'd24: w = uw(OP_EMIT_ONE,  1'b0, C_OUT_BUSY,  A_ONE);
      5'd25: w = uw(OP_NONE,      1'b0, C_ALWAYS,    A_IDLE);
      5'd26: w = uw(OP_EMIT_ZERO, 1'b0, C_OUT_BUSY,  A_ZERO);
      5'd27: w = uw(OP_NONE,      1'b0, C_ALWAYS,    A_IDLE);
      5'd28: w = uw(OP_FIRST,     1'b0, C_ALWAYS,    A_ZERO);
      default: w = uw(OP_NONE,    1'b0, C_ALWAYS,    A_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] clamp_period(input logic [7:0] v);
    logic [7:0] p;
    p = v;
    if (p < MIN_PERIOD) p = MIN_PERIOD;
    if (int'(p) > MAX_PERIOD) p = 8'(MAX_PERIOD);
    return p;
  endfunction

endpackage

// ----- sv/wilder_rsi_stream.sv -----
// Streaming Wilder RSI. Each price transfer (unsigned Q16.16) yields one result transfer:
// rsi_value is gain/(gain+loss) in Q1.16 (65536 = 1.0, also when the average loss is zero)
// and rsi_ready goes high once rsi_period price changes have been seen; before that the
// result is zero. Writing rsi_period (clamped to 2..255) restarts the stream and is taken
// only while the block is idle. One item at a time is handled by a small microcoded
// sequencer around a shared radix-2 divider. A first sample and a seeding sample emit zero
// without a division; the sample that completes the seed and every later sample run two
// 48-step divisions by the period and one 17-step ratio division, the last skipped when the
// average loss is zero. A stalled output holds the sequencer in its emit step.
// The next price is taken while a finished result still waits in the output register.
module wilder_rsi_stream import wrsi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  rsi_period,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] price_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] rsi_value,
  output logic        rsi_ready
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          cw;
  logic            cond_hit;
  logic            in_fire;
  logic            cfg_fire;
  logic            out_busy;
  logic            emit_op;

  logic [7:0]  period;
  logic [31:0] prev;
  logic [8:0]  count;
  logic [47:0] gain_mean;
  logic [47:0] loss_mean;

  logic [31:0] move_up;
  logic [31:0] move_dn;
  logic [55:0] prod;
  logic [48:0] rem;
  logic [48:0] divisor;
  logic [63:0] nsh;
  logic [5:0]  div_cnt;

  logic [8:0]  pp1;
  logic [7:0]  period_m1;
  logic [55:0] half;
  logic [47:0] src_avg;
  logic [31:0] src_move;
  logic [55:0] mul_res;
  logic [55:0] pnum;
  logic [49:0] trial;
  logic [49:0] diff;
  logic        q_bit;
  logic [48:0] total;

  assign cw        = ucode_rom(pc);
  assign cfg_ready = (pc == A_IDLE);
  assign in_ready  = (pc == A_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_busy  = out_valid && !out_ready;
  assign emit_op   = (cw.op == OP_EMIT_Q) || (cw.op == OP_EMIT_ONE) || (cw.op == OP_EMIT_ZERO);

  always_comb begin
    pp1       = {1'b0, period} + 9'd1;
    period_m1 = period - 8'd1;
    half      = 56'(period[7:1]);
    src_avg   = cw.sel_loss ? loss_mean : gain_mean;
    src_move  = cw.sel_loss ? move_dn : move_up;
    mul_res   = 56'(src_avg) * 56'(period_m1);
    if (cw.op == OP_SEED_LOAD) begin
      pnum = {src_avg[39:0], 16'b0} + half;
    end else begin
      pnum = prod + {8'b0, src_move, 16'b0} + half;
    end
    trial = {rem, nsh[63]};
    diff  = trial - {1'b0, divisor};
    q_bit = (trial >= {1'b0, divisor});
    total = {1'b0, gain_mean} + {1'b0, loss_mean};
  end

  always_comb begin
    unique case (cw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_IN:     cond_hit = !in_fire;
      C_FIRST:     cond_hit = (count == 9'd0);
      C_SMOOTH:    cond_hit = (count >= pp1);
      C_SEEDING:   cond_hit = (count < pp1);
      C_DIV_MORE:  cond_hit = (div_cnt != 6'd1);
      C_LOSS_ZERO: cond_hit = (loss_mean == 48'd0);
      C_OUT_BUSY:  cond_hit = out_busy;
      default:     cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? cw.target : pc + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= A_IDLE;
      period    <= RESET_PERIOD;
      prev      <= '0;
      count     <= '0;
      gain_mean <= '0;
      loss_mean <= '0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (emit_op && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire) begin
        period    <= clamp_period(rsi_period);
        prev      <= '0;
        count     <= '0;
        gain_mean <= '0;
        loss_mean <= '0;
      end
      unique case (cw.op)
        OP_ACCEPT: begin
          if (in_fire) begin
            prev <= price_sample;
          end
        end
        OP_FIRST: count <= 9'd1;
        OP_SEED_ADD: begin
          gain_mean <= gain_mean + 48'(move_up);
          loss_mean <= loss_mean + 48'(move_dn);
          count     <= count + 9'd1;
        end
        OP_STORE: begin
          if (cw.sel_loss) begin
            loss_mean <= nsh[47:0];
          end else begin
            gain_mean <= nsh[47:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_ACCEPT: begin
        move_up <= (price_sample > prev) ? price_sample - prev : 32'd0;
        move_dn <= (price_sample < prev) ? prev - price_sample : 32'd0;
      end
      OP_MUL: prod <= mul_res;
      OP_SEED_LOAD, OP_WILD_LOAD: begin
        rem     <= {41'b0, pnum[55:48]};
        nsh     <= {pnum[47:0], 16'b0};
        divisor <= {41'b0, period};
        div_cnt <= DIV_P_STEPS;
      end
      OP_RSI_LOAD: begin
        rem     <= {2'b0, gain_mean[47:1]};
        nsh     <= {gain_mean[0], 63'b0};
        divisor <= total;
        div_cnt <= DIV_R_STEPS;
      end
      OP_DIV_STEP: begin
        rem     <= q_bit ? diff[48:0] : trial[48:0];
        nsh     <= {nsh[62:0], q_bit};
        div_cnt <= div_cnt - 6'd1;
      end
      OP_EMIT_Q: begin
        if (!out_busy) begin
          rsi_value <= nsh[16:0];
          rsi_ready <= 1'b1;
        end
      end
      OP_EMIT_ONE: begin
        if (!out_busy) begin
          rsi_value <= RSI_ONE;
          rsi_ready <= 1'b1;
        end
      end
      OP_EMIT_ZERO: begin
        if (!out_busy) begin
          rsi_value <= 17'd0;
          rsi_ready <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> pc == A_DISPATCH)
    else $error("accepted price did not advance to dispatch");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (count == 9'd0) && (gain_mean == 48'd0) && (loss_mean == 48'd0))
    else $error("period write did not clear the stream state");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_DIV_STEP) |-> (divisor != 49'd0))
    else $error("division step with zero divisor");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsi_ready) |-> (rsi_value == 17'd0))
    else $error("non-ready result carries a value");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rsi_value <= RSI_ONE))
    else $error("rsi_value above 1.0");

endmodule
